// ----- sv/text_console_cursor_scroll_assert.svh -----
// assertion macros for the text console cursor and scroll block
// no dependencies; included by the top level only
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_ASSERT_SVH

// same-cycle implication
`define TCCS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TCCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/tccs_pkg.sv -----
// shared types and codes for the text console cursor and scroll block
// no dependencies
package tccs_pkg;

   localparam int CELL_W = 16;

   typedef logic [CELL_W-1:0] cell_type;
   typedef logic [2:0] state_type;
   typedef logic [1:0] op_type;
   typedef logic [1:0] req_kind_type;

   localparam cell_type BLANK_CELL = 16'h0020;
   localparam logic [7:0] NEWLINE_CODE = 8'd10;
   localparam logic [7:0] NULL_CODE = 8'd0;

   localparam req_kind_type REQ_PUT = 2'd0;
   localparam req_kind_type REQ_READ = 2'd1;
   localparam req_kind_type REQ_CLEAR = 2'd2;

   localparam op_type OP_INIT = 2'd0;
   localparam op_type OP_PUT = 2'd1;
   localparam op_type OP_CLEAR = 2'd2;

   localparam state_type ST_IDLE = 3'd0;
   localparam state_type ST_COPY = 3'd1;
   localparam state_type ST_FILL = 3'd2;
   localparam state_type ST_PUT = 3'd3;
   localparam state_type ST_READ = 3'd4;

endpackage

// ----- sv/tccs_cell_ram.sv -----
// character cell store: one write port, one registered read port
// depends on tccs_pkg
module tccs_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int ADDR_W = 11
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  tccs_pkg::cell_type  wr_data,
   input  logic [ADDR_W-1:0]   rd_addr,
   output tccs_pkg::cell_type  rd_data
);

   tccs_pkg::cell_type mem [DEPTH];
   tccs_pkg::cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/text_console_cursor_scroll.sv -----
// Items taken only in idle; zero byte or unused type answered directly, put/read via ST_PUT/ST_READ.
// Scrolling put: ST_COPY, ST_FILL, then ST_PUT; one cell copy or blank per cycle on the ram.
// Clear: ST_FILL writes one blank cell per cycle through the single write port.
// Results cannot be stalled; the strobe is high for exactly one cycle per item.
// Reset (synchronous) zeroes the cursor and blanks the store through ST_FILL, busy meanwhile.
// Depends on tccs_pkg, tccs_cell_ram and text_console_cursor_scroll_assert.svh.
`include "text_console_cursor_scroll_assert.svh"

module text_console_cursor_scroll #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25,
   localparam int CELLS = COLUMNS * ROWS,
   localparam int IDX_W = $clog2(CELLS),
   localparam int COL_W = $clog2(COLUMNS),
   localparam int ROW_W = $clog2(ROWS + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [7:0]        req_char_code,
   input  logic [7:0]        req_color_attr,
   input  logic [IDX_W-1:0]  req_cell_index,
   output logic              rsp_strobe,
   output logic [15:0]       rsp_cell_data,
   output logic [COL_W-1:0]  rsp_cursor_col,
   output logic [ROW_W-1:0]  rsp_cursor_row
);

   localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(CELLS - 1);
   localparam logic [IDX_W-1:0] LAST_ROW_BASE = IDX_W'(CELLS - COLUMNS);
   localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(COLUMNS);
   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] PENDING_ROW = ROW_W'(ROWS);
   localparam logic [ROW_W-1:0] BOTTOM_ROW = ROW_W'(ROWS - 1);

   tccs_pkg::state_type state_ff, state_in;
   tccs_pkg::op_type op_ff, op_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [7:0] char_ff, char_in;
   logic [7:0] attr_ff, attr_in;
   logic rd_ok_ff, rd_ok_in;
   logic copy_wr_ff, copy_wr_in;
   logic [IDX_W-1:0] copy_dst_ff, copy_dst_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   tccs_pkg::cell_type rsp_data_ff, rsp_data_in;

   logic ram_we;
   logic [IDX_W-1:0] ram_wa;
   tccs_pkg::cell_type ram_wd;
   logic [IDX_W-1:0] ram_ra;
   tccs_pkg::cell_type ram_rd;
   logic [IDX_W-1:0] cursor_pos;
   logic index_ok;

   assign cursor_pos = IDX_W'(row_ff) * ROW_STEP + IDX_W'(col_ff);
   assign index_ok = {1'b0, req_cell_index} < (IDX_W + 1)'(CELLS);

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      cnt_in = cnt_ff;
      col_in = col_ff;
      row_in = row_ff;
      char_in = char_ff;
      attr_in = attr_ff;
      rd_ok_in = rd_ok_ff;
      copy_wr_in = 1'b0;
      copy_dst_in = copy_dst_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in = '0;
      ram_ra = '0;
      ram_we = 1'b0;
      ram_wa = cnt_ff;
      ram_wd = tccs_pkg::BLANK_CELL;

      // pending copy write from the previous scroll read
      if (copy_wr_ff) begin
         ram_we = 1'b1;
         ram_wa = copy_dst_ff;
         ram_wd = ram_rd;
      end

      case (state_ff)
         tccs_pkg::ST_IDLE: begin
            if (start) begin
               char_in = req_char_code;
               attr_in = req_color_attr;
               case (req_type)
                  tccs_pkg::REQ_PUT: begin
                     if (req_char_code == tccs_pkg::NULL_CODE) begin
                        rsp_strobe_in = 1'b1;
                     end else if (row_ff == PENDING_ROW) begin
                        row_in = BOTTOM_ROW;
                        cnt_in = ROW_STEP;
                        op_in = tccs_pkg::OP_PUT;
                        state_in = tccs_pkg::ST_COPY;
                     end else begin
                        state_in = tccs_pkg::ST_PUT;
                     end
                  end
                  tccs_pkg::REQ_READ: begin
                     ram_ra = index_ok ? req_cell_index : '0;
                     rd_ok_in = index_ok;
                     state_in = tccs_pkg::ST_READ;
                  end
                  tccs_pkg::REQ_CLEAR: begin
                     cnt_in = '0;
                     op_in = tccs_pkg::OP_CLEAR;
                     state_in = tccs_pkg::ST_FILL;
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         tccs_pkg::ST_COPY: begin
            ram_ra = cnt_ff;
            copy_wr_in = 1'b1;
            copy_dst_in = cnt_ff - ROW_STEP;
            if (cnt_ff == LAST_CELL) begin
               cnt_in = LAST_ROW_BASE;
               state_in = tccs_pkg::ST_FILL;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         tccs_pkg::ST_FILL: begin
            if (!copy_wr_ff) begin
               ram_we = 1'b1;
               ram_wa = cnt_ff;
               ram_wd = tccs_pkg::BLANK_CELL;
               if (cnt_ff == LAST_CELL) begin
                  case (op_ff)
                     tccs_pkg::OP_PUT: begin
                        state_in = tccs_pkg::ST_PUT;
                     end
                     tccs_pkg::OP_CLEAR: begin
                        rsp_strobe_in = 1'b1;
                        state_in = tccs_pkg::ST_IDLE;
                     end
                     default: begin
                        state_in = tccs_pkg::ST_IDLE;
                     end
                  endcase
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         tccs_pkg::ST_PUT: begin
            if (char_ff == tccs_pkg::NEWLINE_CODE) begin
               col_in = '0;
               row_in = row_ff + 1'b1;
            end else begin
               ram_we = 1'b1;
               ram_wa = cursor_pos;
               ram_wd = {attr_ff, char_ff};
               if (col_ff == LAST_COL) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
            rsp_strobe_in = 1'b1;
            state_in = tccs_pkg::ST_IDLE;
         end
         tccs_pkg::ST_READ: begin
            rsp_data_in = rd_ok_ff ? ram_rd : '0;
            rsp_strobe_in = 1'b1;
            state_in = tccs_pkg::ST_IDLE;
         end
         default: begin
            state_in = tccs_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tccs_pkg::ST_FILL;
         op_ff <= tccs_pkg::OP_INIT;
         cnt_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         copy_wr_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff <= op_in;
         cnt_ff <= cnt_in;
         col_ff <= col_in;
         row_ff <= row_in;
         copy_wr_ff <= copy_wr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      attr_ff <= attr_in;
      rd_ok_ff <= rd_ok_in;
      copy_dst_ff <= copy_dst_in;
      rsp_data_ff <= rsp_data_in;
   end

   tccs_cell_ram #(
      .DEPTH (CELLS),
      .ADDR_W(IDX_W)
   ) u_cell_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   assign busy = (state_ff != tccs_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_cell_data = rsp_data_ff;
   assign rsp_cursor_col = col_ff;
   assign rsp_cursor_row = row_ff;

   `TCCS_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, rsp_strobe || busy, "item taken but neither answered nor in progress")
   `TCCS_ASSERT_NOW(a_no_rsp_in_copy, clock, reset, state_ff == tccs_pkg::ST_COPY, !rsp_strobe, "result strobe during scroll copy")
   `TCCS_ASSERT_NOW(a_cursor_range, clock, reset, rsp_strobe, (row_ff <= PENDING_ROW) && (col_ff <= LAST_COL), "cursor out of range at result")
   `TCCS_ASSERT_NOW(a_copy_source, clock, reset, copy_wr_ff, $past(state_ff == tccs_pkg::ST_COPY), "copy write without a scroll read")

endmodule
